/* design/dtyp_pkg.sv */
// dtyp_pkg: shared widths, constants, types and helpers for direction_to_yaw_pitch
// used by dtyp_cell, dtyp_cordic and direction_to_yaw_pitch
`default_nettype none
package dtyp_pkg;

    localparam int ITERS = 22;
    localparam int CW    = 36;
    localparam int ZW    = 25;
    localparam int DW    = 33;
    localparam int VW    = 32;
    localparam int SHW   = 6;
    localparam int LW    = 34;
    localparam int KW    = 30;
    localparam int YW    = 17;
    localparam int PW    = 15;

    localparam logic [KW-1:0]        KINV = 30'd652032874;
    localparam logic signed [ZW-1:0] Z180 = 25'sd5898240;
    localparam logic signed [ZW-1:0] Z90  = 25'sd2949120;

    localparam logic signed [YW:0] YAW_LO   = -18'sd34560;
    localparam logic signed [YW:0] YAW_HI   = 18'sd11520;
    localparam logic signed [YW:0] PITCH_LO = -18'sd11520;
    localparam logic signed [YW:0] PITCH_HI = 18'sd11520;

    typedef struct packed {
        logic vld;
        logic zero;
    } t_ctl;

    function automatic logic signed [ZW-1:0] atan_step(input int i);
        logic signed [ZW-1:0] r;
        case (i)
            0:       r = 25'sd1474560;
            1:       r = 25'sd870484;
            2:       r = 25'sd459940;
            3:       r = 25'sd233473;
            4:       r = 25'sd117189;
            5:       r = 25'sd58652;
            6:       r = 25'sd29333;
            7:       r = 25'sd14667;
            8:       r = 25'sd7334;
            9:       r = 25'sd3667;
            10:      r = 25'sd1833;
            11:      r = 25'sd917;
            12:      r = 25'sd458;
            13:      r = 25'sd229;
            14:      r = 25'sd115;
            15:      r = 25'sd57;
            16:      r = 25'sd29;
            17:      r = 25'sd14;
            18:      r = 25'sd7;
            19:      r = 25'sd4;
            20:      r = 25'sd2;
            21:      r = 25'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

    // shift that brings the top set bit to bit 30
    function automatic logic signed [SHW-1:0] norm_shift(input logic [DW-1:0] m);
        logic signed [SHW-1:0] s;
        s = '0;
        for (int p = 0; p < DW; p++) begin
            if (m[p]) begin
                s = SHW'(30 - p);
            end
        end
        return s;
    endfunction

    function automatic logic signed [VW-1:0] scale(input logic signed [DW-1:0] v,
                                                   input logic signed [SHW-1:0] s);
        logic signed [DW-1:0] t;
        logic [SHW-1:0]       nsh;
        nsh = SHW'(-s);
        if (!s[SHW-1]) begin
            t = v <<< s[4:0];
        end else begin
            t = v >>> nsh;
        end
        return t[VW-1:0];
    endfunction

    // round to 1/128 degree, ties upward, then clamp
    function automatic logic signed [YW-1:0] to_out(input logic signed [ZW:0] a,
                                                    input logic signed [YW:0] lo,
                                                    input logic signed [YW:0] hi);
        logic signed [ZW:0] t;
        logic signed [YW:0] r;
        t = (a + 26'sd128) >>> 8;
        r = t[YW:0];
        if (r < lo) begin
            r = lo;
        end
        if (r > hi) begin
            r = hi;
        end
        return r[YW-1:0];
    endfunction

endpackage
`default_nettype wire

/* design/dtyp_cell.sv */
// dtyp_cell: one vectoring rotation step with its pipeline register
// depends on dtyp_pkg
`default_nettype none
module dtyp_cell #(
    parameter int I   = 0,
    parameter int W   = dtyp_pkg::CW,
    parameter int SBW = 1
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_en,
    input  wire dtyp_pkg::t_ctl               i_ctl,
    input  wire logic signed [W-1:0]          i_x,
    input  wire logic signed [W-1:0]          i_y,
    input  wire logic signed [dtyp_pkg::ZW-1:0] i_z,
    input  wire logic [SBW-1:0]               i_sb,
    output dtyp_pkg::t_ctl                    o_ctl,
    output logic signed [W-1:0]               o_x,
    output logic signed [W-1:0]               o_y,
    output logic signed [dtyp_pkg::ZW-1:0]    o_z,
    output logic [SBW-1:0]                    o_sb
);

    dtyp_pkg::t_ctl                  r_ctl;
    logic signed [W-1:0]             r_x, r_y, n_x, n_y;
    logic signed [dtyp_pkg::ZW-1:0]  r_z, n_z;
    logic [SBW-1:0]                  r_sb;
    logic signed [W-1:0]             xs, ys;

    always_comb begin
        xs = i_x >>> I;
        ys = i_y >>> I;
        if (!i_y[W-1]) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + dtyp_pkg::atan_step(I);
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - dtyp_pkg::atan_step(I);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
        if (i_en) begin
            r_x  <= n_x;
            r_y  <= n_y;
            r_z  <= n_z;
            r_sb <= i_sb;
        end
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;
    assign o_sb  = r_sb;

endmodule
`default_nettype wire

/* design/dtyp_cordic.sv */
// dtyp_cordic: half-plane fold followed by a chain of rotation cells, atan2 and length
// depends on dtyp_pkg and dtyp_cell
`default_nettype none
module dtyp_cordic #(
    parameter int W   = dtyp_pkg::CW,
    parameter int SBW = 1
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_en,
    input  wire                               i_vld,
    input  wire logic signed [W-1:0]          i_x,
    input  wire logic signed [W-1:0]          i_y,
    input  wire logic [SBW-1:0]               i_sb,
    output logic                              o_vld,
    output logic signed [W-1:0]               o_len,
    output logic signed [dtyp_pkg::ZW-1:0]    o_z,
    output logic [SBW-1:0]                    o_sb
);

    localparam int N = dtyp_pkg::ITERS;

    dtyp_pkg::t_ctl                  c_ctl [0:N];
    logic signed [W-1:0]             c_x   [0:N];
    logic signed [W-1:0]             c_y   [0:N];
    logic signed [dtyp_pkg::ZW-1:0]  c_z   [0:N];
    logic [SBW-1:0]                  c_sb  [0:N];

    dtyp_pkg::t_ctl                  r_ctl, n_ctl;
    logic signed [W-1:0]             r_x, r_y, n_x, n_y;
    logic signed [dtyp_pkg::ZW-1:0]  r_z, n_z;
    logic [SBW-1:0]                  r_sb;

    // fold left half-plane onto the right
    always_comb begin
        n_ctl.vld  = i_vld;
        n_ctl.zero = (i_x == '0) && (i_y == '0);
        if (i_x[W-1]) begin
            n_x = -i_x;
            n_y = -i_y;
            n_z = i_y[W-1] ? -dtyp_pkg::Z180 : dtyp_pkg::Z180;
        end else begin
            n_x = i_x;
            n_y = i_y;
            n_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
        if (i_en) begin
            r_x  <= n_x;
            r_y  <= n_y;
            r_z  <= n_z;
            r_sb <= i_sb;
        end
    end

    assign c_ctl[0] = r_ctl;
    assign c_x[0]   = r_x;
    assign c_y[0]   = r_y;
    assign c_z[0]   = r_z;
    assign c_sb[0]  = r_sb;

    for (genvar g = 0; g < N; g++) begin : g_cell
        dtyp_cell #(
            .I   (g),
            .W   (W),
            .SBW (SBW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_ctl   (c_ctl[g]),
            .i_x     (c_x[g]),
            .i_y     (c_y[g]),
            .i_z     (c_z[g]),
            .i_sb    (c_sb[g]),
            .o_ctl   (c_ctl[g+1]),
            .o_x     (c_x[g+1]),
            .o_y     (c_y[g+1]),
            .o_z     (c_z[g+1]),
            .o_sb    (c_sb[g+1])
        );
    end

    // zero vector answers angle 0 and length 0
    assign o_vld = c_ctl[N].vld;
    assign o_len = c_ctl[N].zero ? '0 : c_x[N];
    assign o_z   = c_ctl[N].zero ? '0 : c_z[N];
    assign o_sb  = c_sb[N];

endmodule
`default_nettype wire

/* design/direction_to_yaw_pitch.sv */
// direction_to_yaw_pitch: yaw and pitch of the vector between two 3D positions
// depends on dtyp_pkg and dtyp_cordic (two rotation cell chains)
//
// Input channel: i_valid / o_stall carry one pair of positions (32-bit signed,
// 8 fraction bits). Output channel: o_valid / i_stall carry yaw (17 bits) and
// pitch (15 bits) in 1/128 degree. A transfer happens when valid is high and
// stall is low.
// One transfer per cycle unless stalled; every pipeline stage holds one item.
// Pipeline order from input transfer to o_valid: difference, magnitude and
// normalisation registers, the yaw rotation chain (fold plus 22 cells), the
// length multiply registers, the pitch rotation chain and the output register.
// When the receiver stalls a valid result the whole pipeline holds and o_stall
// is raised; otherwise the input is never stalled.
// Reset clears all valid flags; the block is ready in the first cycle after it.
`default_nettype none
module direction_to_yaw_pitch (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  wire logic signed [31:0] i_from_x,
    input  wire logic signed [31:0] i_from_y,
    input  wire logic signed [31:0] i_from_z,
    input  wire logic signed [31:0] i_to_x,
    input  wire logic signed [31:0] i_to_y,
    input  wire logic signed [31:0] i_to_z,
    output logic                   o_valid,
    input  wire                    i_stall,
    output logic signed [16:0]     o_yaw,
    output logic signed [14:0]     o_pitch
);

    localparam int DW  = dtyp_pkg::DW;
    localparam int VW  = dtyp_pkg::VW;
    localparam int CW  = dtyp_pkg::CW;
    localparam int ZW  = dtyp_pkg::ZW;
    localparam int SHW = dtyp_pkg::SHW;
    localparam int LW  = dtyp_pkg::LW;
    localparam int KW  = dtyp_pkg::KW;
    localparam int HL  = 17;
    localparam int PPW = LW - HL + KW;

    logic en;

    logic                  r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld, r_ov;
    logic signed [DW-1:0]  r1_dx, r1_dy, r1_dz, r2_dx, r2_dy, r2_dz, r3_dx, r3_dy, r3_dz;
    logic [DW-1:0]         r2_m1, r2_m2, n_m1, n_m2, ax, ay, az;
    logic signed [SHW-1:0] r3_s1, r3_s;
    logic signed [VW-1:0]  r4_xs, r4_ys, r4_zs;
    logic [SHW-1:0]        r4_sd;

    logic                  y_vld;
    logic signed [CW-1:0]  y_len;
    logic signed [ZW-1:0]  y_z;
    logic [VW+SHW-1:0]     y_sb;
    logic signed [VW-1:0]  y_ys;
    logic [SHW-1:0]        y_sd;
    logic [LW-1:0]         lenc;

    logic [PPW-1:0]        r5_phi, r5_plo;
    logic signed [ZW-1:0]  r5_ya, r6_ya;
    logic signed [VW-1:0]  r5_ys, r6_ys;
    logic [SHW-1:0]        r5_sd;
    logic [63:0]           prod;
    logic [LW-1:0]         n_hyp, r6_hyp;

    logic                  p_vld;
    logic signed [CW-1:0]  p_len;
    logic signed [ZW-1:0]  p_z;
    logic [ZW-1:0]         p_sb;
    logic signed [ZW:0]    a_yaw, a_pitch;

    assign en      = !(r_ov && i_stall);
    assign o_stall = r_ov && i_stall;

    always_comb begin
        ax   = r1_dx[DW-1] ? DW'(-r1_dx) : DW'(r1_dx);
        ay   = r1_dy[DW-1] ? DW'(-r1_dy) : DW'(r1_dy);
        az   = r1_dz[DW-1] ? DW'(-r1_dz) : DW'(r1_dz);
        n_m1 = (ax > az) ? ax : az;
        n_m2 = (n_m1 > ay) ? n_m1 : ay;
    end

    always_comb begin
        lenc  = y_len[CW-1] ? '0 : y_len[LW-1:0];
        prod  = 64'({r5_phi, {HL{1'b0}}}) + 64'(r5_plo);
        n_hyp = LW'(prod[63:30] >> r5_sd);
        a_yaw   = {p_sb[ZW-1], p_sb} - {dtyp_pkg::Z90[ZW-1], dtyp_pkg::Z90};
        a_pitch = -{p_z[ZW-1], p_z};
    end

    assign y_ys = y_sb[VW+SHW-1:SHW];
    assign y_sd = y_sb[SHW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r_ov   <= 1'b0;
        end else if (en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= y_vld;
            r6_vld <= r5_vld;
            r_ov   <= p_vld;
        end
        if (en) begin
            r1_dx <= {i_to_x[31], i_to_x} - {i_from_x[31], i_from_x};
            r1_dy <= {i_to_y[31], i_to_y} - {i_from_y[31], i_from_y};
            r1_dz <= {i_to_z[31], i_to_z} - {i_from_z[31], i_from_z};
            r2_dx <= r1_dx;
            r2_dy <= r1_dy;
            r2_dz <= r1_dz;
            r2_m1 <= n_m1;
            r2_m2 <= n_m2;
            r3_dx <= r2_dx;
            r3_dy <= r2_dy;
            r3_dz <= r2_dz;
            r3_s1 <= dtyp_pkg::norm_shift(r2_m1);
            r3_s  <= dtyp_pkg::norm_shift(r2_m2);
            r4_xs <= dtyp_pkg::scale(r3_dx, r3_s1);
            r4_zs <= dtyp_pkg::scale(r3_dz, r3_s1);
            r4_ys <= dtyp_pkg::scale(r3_dy, r3_s);
            r4_sd <= SHW'(r3_s1 - r3_s);
            r5_phi <= PPW'(lenc[LW-1:HL] * dtyp_pkg::KINV);
            r5_plo <= PPW'(lenc[HL-1:0] * dtyp_pkg::KINV);
            r5_ya  <= y_z;
            r5_ys  <= y_ys;
            r5_sd  <= y_sd;
            r6_hyp <= n_hyp;
            r6_ya  <= r5_ya;
            r6_ys  <= r5_ys;
            o_yaw   <= dtyp_pkg::to_out(a_yaw, dtyp_pkg::YAW_LO, dtyp_pkg::YAW_HI);
            o_pitch <= 15'(dtyp_pkg::to_out(a_pitch, dtyp_pkg::PITCH_LO,
                                            dtyp_pkg::PITCH_HI));
        end
    end

    assign o_valid = r_ov;

    dtyp_cordic #(
        .W   (CW),
        .SBW (VW + SHW)
    ) u_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r4_vld),
        .i_x     ({{(CW-VW){r4_xs[VW-1]}}, r4_xs}),
        .i_y     ({{(CW-VW){r4_zs[VW-1]}}, r4_zs}),
        .i_sb    ({r4_ys, r4_sd}),
        .o_vld   (y_vld),
        .o_len   (y_len),
        .o_z     (y_z),
        .o_sb    (y_sb)
    );

    dtyp_cordic #(
        .W   (CW),
        .SBW (ZW)
    ) u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r6_vld),
        .i_x     ({{(CW-LW){1'b0}}, r6_hyp}),
        .i_y     ({{(CW-VW){r6_ys[VW-1]}}, r6_ys}),
        .i_sb    (r6_ya),
        .o_vld   (p_vld),
        .o_len   (p_len),
        .o_z     (p_z),
        .o_sb    (p_sb)
    );

    // the pitch chain carries the yaw angle alongside; its length is not needed
    logic unused_plen;
    assign unused_plen = ^p_len;

`ifndef SYNTHESIS
    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_yaw >= -17'sd34560) && (o_yaw <= 17'sd11520))
        else $error("yaw out of range");
    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pitch >= -15'sd11520) && (o_pitch <= 15'sd11520))
        else $error("pitch out of range");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r6_vld && o_stall |=> r6_vld && $stable(r6_hyp))
        else $error("length stage moved while stalled");
`endif

endmodule
`default_nettype wire

/* tb/dtyp_checker.sv */
// dtyp_checker: watches both channels of direction_to_yaw_pitch, predicts yaw and pitch
// for every input transfer and compares each output transfer in order
// depends on nothing but the port widths of the block
`timescale 1ns / 1ps
module dtyp_checker (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    input  wire               i_in_stall,
    input  wire signed [31:0] i_from_x,
    input  wire signed [31:0] i_from_y,
    input  wire signed [31:0] i_from_z,
    input  wire signed [31:0] i_to_x,
    input  wire signed [31:0] i_to_y,
    input  wire signed [31:0] i_to_z,
    input  wire               i_out_valid,
    input  wire               i_out_stall,
    input  wire signed [16:0] i_yaw,
    input  wire signed [14:0] i_pitch,
    output int                o_errors,
    output int                o_pending,
    output int                o_results
);

    localparam longint DEG = 32768;
    localparam longint KINV_Q30 = 652032874;

    typedef struct packed {
        logic signed [16:0] yaw;
        logic signed [14:0] pitch;
    } angles_t;

    angles_t angle_q[$];

    longint arc_tab[22] = '{1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
                            7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};

    function automatic longint magnitude(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic int lead_shift(longint m);
        int s;
        s = 0;
        if (m == 0) return 0;
        while (m >= 64'sd2147483648) begin m = m >>> 1; s--; end
        while (m < 64'sd1073741824) begin m = m <<< 1; s++; end
        return s;
    endfunction

    function automatic longint rescale(longint v, int s);
        if (s >= 0) return v <<< s;
        return v >>> (-s);
    endfunction

    function automatic longint vector_angle(longint x, longint y, output longint len);
        longint z, xs, ys;
        z = 0;
        len = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? 180 * DEG : -180 * DEG;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 22; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += arc_tab[i];
            end else begin
                x -= ys; y += xs; z -= arc_tab[i];
            end
        end
        len = x;
        return z;
    endfunction

    function automatic longint round_clamp(longint a, longint lo, longint hi);
        longint r;
        r = (a + 128) >>> 8;
        if (r < lo) r = lo;
        if (r > hi) r = hi;
        return r;
    endfunction

    function automatic angles_t predict_angles(longint fx, longint fy, longint fz,
                                               longint tx, longint ty, longint tz);
        longint dx, dy, dz, m1, m2, len, unused, hyp, ya, pa;
        longint unsigned prod;
        int s1, s;
        angles_t r;
        dx = tx - fx;
        dy = ty - fy;
        dz = tz - fz;
        m1 = magnitude(dx) > magnitude(dz) ? magnitude(dx) : magnitude(dz);
        m2 = m1 > magnitude(dy) ? m1 : magnitude(dy);
        s1 = lead_shift(m1);
        s = lead_shift(m2);
        ya = vector_angle(rescale(dx, s1), rescale(dz, s1), len);
        if (len < 0) len = 0;
        prod = longint'(unsigned'(len)) * longint'(unsigned'(KINV_Q30));
        hyp = longint'(prod >> 30);
        if (m1 == 0) hyp = 0;
        hyp = rescale(hyp, s - s1);
        pa = vector_angle(hyp, rescale(dy, s), unused);
        r.yaw = 17'(round_clamp(ya - 90 * DEG, -34560, 11520));
        r.pitch = 15'(round_clamp(-pa, -11520, 11520));
        return r;
    endfunction

    initial begin
        o_errors = 0;
        o_results = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        angles_t want;
        if (i_rst_n) begin
            if (i_valid && !i_in_stall) begin
                angle_q.push_back(predict_angles(i_from_x, i_from_y, i_from_z,
                                                 i_to_x, i_to_y, i_to_z));
            end
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (angle_q.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected result yaw=%0d pitch=%0d", $time, i_yaw, i_pitch);
                end else begin
                    want = angle_q.pop_front();
                    if (want.yaw !== i_yaw) begin
                        o_errors++;
                        $display("%0t: yaw expected %0d actual %0d", $time, want.yaw, i_yaw);
                    end
                    if (want.pitch !== i_pitch) begin
                        o_errors++;
                        $display("%0t: pitch expected %0d actual %0d", $time, want.pitch,
                                 i_pitch);
                    end
                end
            end
        end
        o_pending = angle_q.size();
    end

endmodule

/* tb/tb.sv */
// tb: stimulus and verdict for direction_to_yaw_pitch
// depends on the block under test and on dtyp_checker, which predicts and compares
`timescale 1ns / 1ps
module tb;

    localparam int N_RANDOM = 2000;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 80;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] from_x, from_y, from_z, to_x, to_y, to_z;
    logic               out_valid;
    logic               out_stall;
    logic signed [16:0] yaw;
    logic signed [14:0] pitch;
    int                 errors, pending, results;
    int                 send_idle_pct, recv_idle_pct;
    int                 quiet_cycles;
    int                 sent;

    direction_to_yaw_pitch dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_from_x(from_x), .i_from_y(from_y), .i_from_z(from_z),
        .i_to_x(to_x), .i_to_y(to_y), .i_to_z(to_z),
        .o_valid(out_valid), .i_stall(out_stall), .o_yaw(yaw), .o_pitch(pitch)
    );

    dtyp_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_in_stall(in_stall),
        .i_from_x(from_x), .i_from_y(from_y), .i_from_z(from_z),
        .i_to_x(to_x), .i_to_y(to_y), .i_to_z(to_z),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_yaw(yaw), .i_pitch(pitch),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    initial begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout with %0d results outstanding", pending);
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one position pair, held until transferred; random gap afterwards
    task automatic send_pair(logic signed [31:0] fx, fy, fz, tx, ty, tz);
        from_x = fx; from_y = fy; from_z = fz;
        to_x = tx; to_y = ty; to_z = tz;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        sent++;
        @(negedge clk);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            while ($urandom_range(99) < send_idle_pct) @(negedge clk);
        end
    endtask

    task automatic send_offset(logic signed [31:0] dx, dy, dz);
        logic signed [31:0] bx, by, bz;
        bx = $urandom; by = $urandom; bz = $urandom;
        send_pair(bx, by, bz, bx + dx, by + dy, bz + dz);
    endtask

    function automatic logic signed [31:0] rand_delta();
        logic signed [31:0] v;
        v = $urandom;
        return v >>> $urandom_range(31);
    endfunction

    initial begin
        logic signed [31:0] mx, mn;
        mx = 32'sh7fffffff;
        mn = 32'sh80000000;
        rst_n = 0; in_valid = 0;
        from_x = 0; from_y = 0; from_z = 0; to_x = 0; to_y = 0; to_z = 0;
        send_idle_pct = 37; recv_idle_pct = 72;
        sent = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // extremes, axes, zero vector and the negative x axis
        send_pair(0, 0, 0, 0, 0, 0);
        send_pair(mx, mx, mx, mn, mn, mn);
        send_pair(mn, mn, mn, mx, mx, mx);
        send_pair(mn, 0, mx, mx, 0, mn);
        send_pair(0, 0, 0, -256, 0, 0);
        send_pair(0, 0, 0, 256, 0, 0);
        send_pair(0, 0, 0, 0, 0, 256);
        send_pair(0, 0, 0, 0, 0, -256);
        send_pair(0, 0, 0, 0, 1, 0);
        send_pair(0, 0, 0, 0, -1, 0);
        send_pair(5, mn, 7, 5, mx, 7);
        send_pair(0, 0, 0, 1, 0, 1);
        send_pair(0, 0, 0, -1, 0, -1);
        send_pair(0, 0, 0, -1, 0, 1);
        send_pair(0, 0, 0, 1, 1, 0);
        send_pair(0, 0, 0, mn, 0, 0);
        send_pair(mx, mx, mx, mx, mx, mx);
        send_pair(0, 0, 0, 1000, -3, -1000);

        // hold off until the pipeline has drained
        in_valid = 0;
        while (pending != 0) @(negedge clk);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) begin
                send_idle_pct = 72; recv_idle_pct = 37;
            end else if (n == 2 * N_RANDOM / 3) begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            case ($urandom_range(3))
                0: send_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                1: send_offset(rand_delta(), rand_delta(), rand_delta());
                2: send_offset(rand_delta(), 0, rand_delta());
                default: send_offset($urandom_range(1) ? 0 : rand_delta(), rand_delta(),
                                     $urandom_range(1) ? 0 : rand_delta());
            endcase
        end
        in_valid = 0;

        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d position pairs (extremes, axes, zero vectors, random spans)",
                 sent);
        $display("%0d results checked under sender and receiver idling", results);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/dtyp_pkg.sv
design/dtyp_cell.sv
design/dtyp_cordic.sv
design/direction_to_yaw_pitch.sv
tb/dtyp_checker.sv
tb/tb.sv
